[rtl/alb_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package alb_pkg;

  localparam int CNT_W      = 16;
  localparam int LUX_W      = 16;
  localparam int BRIGHT_W   = 8;
  localparam int LEVEL_W    = 5;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  localparam int DEF_HISTORY_DEPTH = 4;
  localparam int DEF_LEVEL_MAX     = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MIN_BRIGHTNESS = 2'd0,
    CFG_MAX_BRIGHTNESS = 2'd1,
    CFG_AUTO_ENABLE    = 2'd2
  } cfg_index_t;

  localparam logic [BRIGHT_W-1:0] MIN_BRIGHT_RESET = 8'd10;
  localparam logic [BRIGHT_W-1:0] MAX_BRIGHT_RESET = 8'd255;
  localparam logic [BRIGHT_W-1:0] CUR_BRIGHT_RESET = 8'd255;

  // Channel ratio coefficients in Q1.16 (the first two exceed unity).
  localparam logic [16:0] COEF_A_VIS = 17'd116281;
  localparam logic [16:0] COEF_A_IR  = 17'd72476;
  localparam logic [16:0] COEF_B     = 17'd64383;
  localparam logic [16:0] COEF_C     = 17'd46203;
  localparam logic [16:0] COEF_D     = 17'd11580;

  localparam logic [LUX_W-1:0] LUX_T0 = 16'd10;
  localparam logic [LUX_W-1:0] LUX_T1 = 16'd100;
  localparam logic [LUX_W-1:0] LUX_T2 = 16'd500;
  localparam logic [LUX_W-1:0] LUX_T3 = 16'd5000;

  localparam logic [BRIGHT_W-1:0] BRIGHT_KNEE0 = 8'd128;
  localparam logic [BRIGHT_W-1:0] BRIGHT_KNEE1 = 8'd200;

  typedef enum logic [2:0] {
    SEG_MIN,
    SEG_LOW,
    SEG_MID,
    SEG_HIGH,
    SEG_MAX
  } seg_t;

  // Reciprocals for the ramp divisions; exact for products below 2^20.
  localparam int RAMP_SHIFT   = 33;
  localparam int RAMP_RECIP_W = 28;
  localparam logic [RAMP_RECIP_W-1:0] RAMP_RECIP_LOW =
    28'(((64'd1 << RAMP_SHIFT) + 64'd89) / 64'd90);
  localparam logic [RAMP_RECIP_W-1:0] RAMP_RECIP_MID =
    28'(((64'd1 << RAMP_SHIFT) + 64'd399) / 64'd400);
  localparam logic [RAMP_RECIP_W-1:0] RAMP_RECIP_HIGH =
    28'(((64'd1 << RAMP_SHIFT) + 64'd4499) / 64'd4500);

  // Reciprocal of 255, exact for dividends below 2^16.
  localparam int LEVEL_SHIFT = 24;
  localparam int LEVEL_RECIP = ((1 << LEVEL_SHIFT) + 254) / 255;

  typedef struct packed {
    logic [BRIGHT_W-1:0] min_brightness;
    logic [BRIGHT_W-1:0] max_brightness;
  } bright_cfg_t;

endpackage

`default_nettype wire

[rtl/alb_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface alb_sample_if;
  logic                     valid;
  logic                     ready;
  logic [alb_pkg::CNT_W-1:0] visible_ir_count;
  logic [alb_pkg::CNT_W-1:0] ir_count;
  logic                     read_error;

  modport source (output valid, visible_ir_count, ir_count, read_error, input ready);
  modport sink (input valid, visible_ir_count, ir_count, read_error, output ready);
endinterface

interface alb_result_if;
  logic                        valid;
  logic                        ready;
  logic [alb_pkg::BRIGHT_W-1:0] brightness;
  logic [alb_pkg::LEVEL_W-1:0]  backlight_level;

  modport source (output valid, brightness, backlight_level, input ready);
  modport sink (input valid, brightness, backlight_level, output ready);
endinterface

`default_nettype wire

[rtl/alb_lux.sv]
`timescale 1ns / 1ps
`default_nettype none

module alb_lux (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       auto_enable,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic [alb_pkg::CNT_W-1:0]  visible_ir_count,
  input  wire logic [alb_pkg::CNT_W-1:0]  ir_count,
  input  wire logic                       read_error,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic [alb_pkg::LUX_W-1:0]       lux
);

  logic                      s1_valid;
  logic                      s1_ready;
  logic [alb_pkg::CNT_W-1:0] c0;
  logic [alb_pkg::CNT_W-1:0] c1;
  logic                      err;

  logic        zero_chan;
  logic        band_a;
  logic        band_b;
  logic        band_c;
  logic        band_d;
  logic        no_band;
  logic [16:0] ka;
  logic [16:0] kb;
  logic [32:0] pa_next;
  logic [32:0] pb_next;

  logic                      s2_valid;
  logic                      s2_ready;
  logic [32:0]               pa;
  logic [32:0]               pb;
  logic [alb_pkg::CNT_W-1:0] raw;
  logic                      use_raw;
  logic                      force_zero;

  logic [32:0]               diff;
  logic [alb_pkg::LUX_W-1:0] lux_next;
  logic                      s3_valid;
  logic                      s3_ready;

  assign s1_ready = !s1_valid || s2_ready;
  assign s2_ready = !s2_valid || s3_ready;
  assign s3_ready = !s3_valid || out_ready;
  assign in_ready = s1_ready;

  // Samples taken while auto mode is off are dropped at the input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_ready) begin
      s1_valid <= in_valid && auto_enable;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready && in_valid) begin
      c0  <= visible_ir_count;
      c1  <= ir_count;
      err <= read_error;
    end
  end

  assign zero_chan = (c0 == '0) || (c1 == '0);
  assign band_a    = {c1, 1'b0} < {1'b0, c0};
  assign band_b    = (23'(c1) * 23'd100) < (23'(c0) * 23'd61);
  assign band_c    = (19'(c1) * 19'd5) < (19'(c0) * 19'd4);
  assign band_d    = (20'(c1) * 20'd10) < (20'(c0) * 20'd13);

  always_comb begin
    ka      = '0;
    kb      = '0;
    no_band = 1'b0;
    if (band_a) begin
      ka = alb_pkg::COEF_A_VIS;
      kb = alb_pkg::COEF_A_IR;
    end else if (band_b) begin
      ka = alb_pkg::COEF_B;
      kb = alb_pkg::COEF_B;
    end else if (band_c) begin
      ka = alb_pkg::COEF_C;
      kb = alb_pkg::COEF_C;
    end else if (band_d) begin
      ka = alb_pkg::COEF_D;
      kb = alb_pkg::COEF_D;
    end else begin
      no_band = 1'b1;
    end
  end

  assign pa_next = 33'(ka) * 33'(c0);
  assign pb_next = 33'(kb) * 33'(c1);

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_ready) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_ready && s1_valid) begin
      pa         <= pa_next;
      pb         <= pb_next;
      raw        <= c0;
      use_raw    <= !err && zero_chan;
      force_zero <= err || (!zero_chan && no_band);
    end
  end

  assign diff = pa - pb;

  always_comb begin
    if (force_zero || (!use_raw && (pa <= pb))) begin
      lux_next = '0;
    end else if (use_raw) begin
      lux_next = raw;
    end else if (diff[32]) begin
      lux_next = '1;
    end else begin
      lux_next = diff[31:16];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (s3_ready) begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_ready && s2_valid) begin
      lux <= lux_next;
    end
  end

  assign out_valid = s3_valid;

endmodule

`default_nettype wire

[rtl/alb_avg.sv]
`timescale 1ns / 1ps
`default_nettype none

module alb_avg #(
  parameter int HISTORY_DEPTH = alb_pkg::DEF_HISTORY_DEPTH
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic [alb_pkg::LUX_W-1:0]  lux,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic [alb_pkg::LUX_W-1:0]       avg
);

  localparam int SLOT_W    = $clog2(HISTORY_DEPTH);
  localparam int SUM_W     = alb_pkg::LUX_W + SLOT_W;
  localparam int AVG_SHIFT = SUM_W + SLOT_W;
  localparam int RECIP_W   = AVG_SHIFT + 1;
  localparam int PROD_W    = SUM_W + RECIP_W;
  localparam logic [63:0] AVG_RECIP_FULL =
    ((64'd1 << AVG_SHIFT) + 64'(HISTORY_DEPTH) - 64'd1) / 64'(HISTORY_DEPTH);

  logic [alb_pkg::LUX_W-1:0] hist [HISTORY_DEPTH];
  logic [SLOT_W-1:0]         slot;
  logic [SUM_W-1:0]          sum;
  logic [SUM_W-1:0]          sum_next;
  logic                      s4_valid;
  logic                      s4_ready;
  logic                      load;

  logic [PROD_W-1:0]         avg_prod;
  logic                      s5_valid;
  logic                      s5_ready;

  assign s4_ready = !s4_valid || s5_ready;
  assign s5_ready = !s5_valid || out_ready;
  assign in_ready = s4_ready;
  assign load     = in_valid && s4_ready;

  // The running sum always equals the sum of the window, new entry included.
  assign sum_next = sum - SUM_W'(hist[slot]) + SUM_W'(lux);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < HISTORY_DEPTH; i++) begin
        hist[i] <= '0;
      end
      slot     <= '0;
      sum      <= '0;
      s4_valid <= 1'b0;
    end else begin
      if (s4_ready) begin
        s4_valid <= in_valid;
      end
      if (load) begin
        hist[slot] <= lux;
        sum        <= sum_next;
        slot       <= (slot == SLOT_W'(HISTORY_DEPTH - 1)) ? '0 : slot + 1'b1;
      end
    end
  end

  assign avg_prod = PROD_W'(sum) * PROD_W'(AVG_RECIP_FULL[RECIP_W-1:0]);

  always_ff @(posedge clk) begin
    if (rst) begin
      s5_valid <= 1'b0;
    end else if (s5_ready) begin
      s5_valid <= s4_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s5_ready && s4_valid) begin
      avg <= avg_prod[AVG_SHIFT +: alb_pkg::LUX_W];
    end
  end

  assign out_valid = s5_valid;

endmodule

`default_nettype wire

[rtl/alb_curve.sv]
`timescale 1ns / 1ps
`default_nettype none

module alb_curve #(
  parameter int LEVEL_MAX = alb_pkg::DEF_LEVEL_MAX
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire alb_pkg::bright_cfg_t          cfg,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [alb_pkg::LUX_W-1:0]     avg,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [alb_pkg::BRIGHT_W-1:0]       brightness,
  output logic [alb_pkg::LEVEL_W-1:0]        backlight_level
);

  localparam logic [24:0] LEVEL_COEF = 25'(LEVEL_MAX * alb_pkg::LEVEL_RECIP);

  alb_pkg::seg_t                seg_next;
  logic [12:0]                  dx;
  logic signed [9:0]            dy;
  logic [alb_pkg::BRIGHT_W-1:0] y0_next;
  logic [7:0]                   mag;
  logic [20:0]                  prod_next;

  logic                         s6_valid;
  logic                         s6_ready;
  alb_pkg::seg_t                seg;
  logic [20:0]                  prod;
  logic                         neg;
  logic [alb_pkg::BRIGHT_W-1:0] y0;

  logic [alb_pkg::RAMP_RECIP_W-1:0] recip;
  logic [48:0]                  qprod;
  logic [7:0]                   quot;
  logic [alb_pkg::BRIGHT_W-1:0] bright_next;

  logic                         s7_valid;
  logic                         s7_ready;
  logic [alb_pkg::BRIGHT_W-1:0] bright;
  logic [alb_pkg::BRIGHT_W-1:0] cur_bright;
  logic                         changed;
  logic                         out_free;
  logic [32:0]                  lvl_prod;

  assign s6_ready = !s6_valid || s7_ready;
  assign in_ready = s6_ready;

  // Flat ends use a zero slope so that every segment shares one datapath.
  always_comb begin
    seg_next = alb_pkg::SEG_MAX;
    dx       = '0;
    dy       = '0;
    y0_next  = cfg.max_brightness;
    if (avg < alb_pkg::LUX_T0) begin
      seg_next = alb_pkg::SEG_MIN;
      y0_next  = cfg.min_brightness;
    end else if (avg < alb_pkg::LUX_T1) begin
      seg_next = alb_pkg::SEG_LOW;
      dx       = 13'(avg - alb_pkg::LUX_T0);
      dy       = signed'({2'b00, alb_pkg::BRIGHT_KNEE0}) - signed'({2'b00, cfg.min_brightness});
      y0_next  = cfg.min_brightness;
    end else if (avg < alb_pkg::LUX_T2) begin
      seg_next = alb_pkg::SEG_MID;
      dx       = 13'(avg - alb_pkg::LUX_T1);
      dy       = signed'({2'b00, alb_pkg::BRIGHT_KNEE1}) - signed'({2'b00, alb_pkg::BRIGHT_KNEE0});
      y0_next  = alb_pkg::BRIGHT_KNEE0;
    end else if (avg < alb_pkg::LUX_T3) begin
      seg_next = alb_pkg::SEG_HIGH;
      dx       = 13'(avg - alb_pkg::LUX_T2);
      dy       = signed'({2'b00, cfg.max_brightness}) - signed'({2'b00, alb_pkg::BRIGHT_KNEE1});
      y0_next  = alb_pkg::BRIGHT_KNEE1;
    end
  end

  assign mag       = dy[9] ? 8'(-dy) : 8'(dy);
  assign prod_next = 21'(dx) * 21'(mag);

  always_ff @(posedge clk) begin
    if (rst) begin
      s6_valid <= 1'b0;
    end else if (s6_ready) begin
      s6_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s6_ready && in_valid) begin
      seg  <= seg_next;
      prod <= prod_next;
      neg  <= dy[9];
      y0   <= y0_next;
    end
  end

  always_comb begin
    case (seg)
      alb_pkg::SEG_LOW:  recip = alb_pkg::RAMP_RECIP_LOW;
      alb_pkg::SEG_MID:  recip = alb_pkg::RAMP_RECIP_MID;
      alb_pkg::SEG_HIGH: recip = alb_pkg::RAMP_RECIP_HIGH;
      default:           recip = '0;
    endcase
  end

  // The quotient is taken on the magnitude, so it truncates toward zero.
  assign qprod       = 49'(prod) * 49'(recip);
  assign quot        = qprod[alb_pkg::RAMP_SHIFT +: 8];
  assign bright_next = neg ? y0 - quot : y0 + quot;

  assign changed  = bright != cur_bright;
  assign out_free = !out_valid || out_ready;
  assign s7_ready = !s7_valid || !changed || out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      s7_valid <= 1'b0;
    end else if (s7_ready) begin
      s7_valid <= s6_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s7_ready && s6_valid) begin
      bright <= bright_next;
    end
  end

  assign lvl_prod = 33'(bright) * 33'(LEVEL_COEF);

  // A brightness equal to the current one is retired without a transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      cur_bright <= alb_pkg::CUR_BRIGHT_RESET;
    end else if (out_free) begin
      out_valid <= s7_valid && changed;
      if (s7_valid && changed) begin
        cur_bright <= bright;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && s7_valid && changed) begin
      brightness      <= bright;
      backlight_level <= lvl_prod[alb_pkg::LEVEL_SHIFT +: alb_pkg::LEVEL_W];
    end
  end

endmodule

`default_nettype wire

[rtl/ambient_lux_auto_backlight_unit.sv]
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake      Payload
// sample    in         valid/ready    visible_ir_count, ir_count, read_error
// result    out        valid/ready    brightness, backlight_level
// cfg       in         cfg_wr_en      cfg_index, cfg_data
//
// One sample is taken per cycle while the sample port is ready; a result, when the brightness
// changes, passes through the seven register stages after the input register: products,
// lux, window sum, average, ramp product, brightness and the result register.
// Reset is synchronous; the lux window is cleared at once.
// A stalled result holds in its register while samples that give no result keep
// flowing; each stage fills in turn before the sample port stops.

module ambient_lux_auto_backlight_unit #(
  parameter int HISTORY_DEPTH = alb_pkg::DEF_HISTORY_DEPTH,
  parameter int LEVEL_MAX     = alb_pkg::DEF_LEVEL_MAX
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_wr_en,
  input  wire logic [alb_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [alb_pkg::CFG_DATA_W-1:0]  cfg_data,
  alb_sample_if.sink                           sample,
  alb_result_if.source                         result
);

  alb_pkg::bright_cfg_t cfg;
  logic                 auto_enable;

  logic                      lux_valid;
  logic                      lux_ready;
  logic [alb_pkg::LUX_W-1:0] lux;
  logic                      avg_valid;
  logic                      avg_ready;
  logic [alb_pkg::LUX_W-1:0] avg;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.min_brightness <= alb_pkg::MIN_BRIGHT_RESET;
      cfg.max_brightness <= alb_pkg::MAX_BRIGHT_RESET;
      auto_enable        <= 1'b1;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        alb_pkg::CFG_MIN_BRIGHTNESS: cfg.min_brightness <= cfg_data;
        alb_pkg::CFG_MAX_BRIGHTNESS: cfg.max_brightness <= cfg_data;
        alb_pkg::CFG_AUTO_ENABLE:    auto_enable        <= cfg_data[0];
        default: ;
      endcase
    end
  end

  alb_lux u_lux (
    .clk              (clk),
    .rst              (rst),
    .auto_enable      (auto_enable),
    .in_valid         (sample.valid),
    .in_ready         (sample.ready),
    .visible_ir_count (sample.visible_ir_count),
    .ir_count         (sample.ir_count),
    .read_error       (sample.read_error),
    .out_valid        (lux_valid),
    .out_ready        (lux_ready),
    .lux              (lux)
  );

  alb_avg #(
    .HISTORY_DEPTH (HISTORY_DEPTH)
  ) u_avg (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (lux_valid),
    .in_ready  (lux_ready),
    .lux       (lux),
    .out_valid (avg_valid),
    .out_ready (avg_ready),
    .avg       (avg)
  );

  alb_curve #(
    .LEVEL_MAX (LEVEL_MAX)
  ) u_curve (
    .clk             (clk),
    .rst             (rst),
    .cfg             (cfg),
    .in_valid        (avg_valid),
    .in_ready        (avg_ready),
    .avg             (avg),
    .out_valid       (result.valid),
    .out_ready       (result.ready),
    .brightness      (result.brightness),
    .backlight_level (result.backlight_level)
  );

endmodule

`default_nettype wire

[rtl/alb_checker.sv]
`timescale 1ns / 1ps
`default_nettype none

module alb_checker #(
  parameter int LEVEL_MAX = alb_pkg::DEF_LEVEL_MAX
) (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          result_valid,
  input wire logic                          result_ready,
  input wire logic [alb_pkg::BRIGHT_W-1:0]  brightness,
  input wire logic [alb_pkg::LEVEL_W-1:0]   backlight_level
);

  logic [alb_pkg::BRIGHT_W-1:0] last_bright;

  // Brightness of the last result transfer, starting from the reset value.
  always_ff @(posedge clk) begin
    if (rst) begin
      last_bright <= alb_pkg::CUR_BRIGHT_RESET;
    end else if (result_valid && result_ready) begin
      last_bright <= brightness;
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=>
      result_valid && $stable(brightness) && $stable(backlight_level))
    else $error("result changed while stalled");

  a_reset: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result valid right after reset");

  a_level: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (LEVEL_MAX > 31) || ({3'b000, backlight_level} <= 8'(LEVEL_MAX)))
    else $error("backlight level above its maximum");

  a_change: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> brightness != last_bright)
    else $error("result repeats the previous brightness");

endmodule

bind ambient_lux_auto_backlight_unit alb_checker #(
  .LEVEL_MAX (LEVEL_MAX)
) u_alb_checker (
  .clk             (clk),
  .rst             (rst),
  .result_valid    (result.valid),
  .result_ready    (result.ready),
  .brightness      (result.brightness),
  .backlight_level (result.backlight_level)
);

`default_nettype wire
